>>> hdl/contour_polygon_moments_assert.svh
// assertion macros used by the top level design file
`ifndef CONTOUR_POLYGON_MOMENTS_ASSERT_SVH
`define CONTOUR_POLYGON_MOMENTS_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define CPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// antecedent implies consequent in the next cycle
`define CPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define CPM_ASSERT_IMP(label, ante, cons)
`define CPM_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hdl/cpm_pkg.sv
package cpm_pkg;

  // defaults for the top level parameters
  localparam int COORD_BITS_DEF  = 12;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // input field widths
  localparam int IN_COORD_W = 12;

  // accumulator widths, two's complement
  localparam int W_AREA = 28;
  localparam int W_M1   = 42;
  localparam int W_MXX  = 54;
  localparam int W_MXY  = 55;
  localparam int W_MYY  = 54;

  // result field widths
  localparam int W_CNT_OUT  = 16;
  localparam int W_AREA_OUT = 26;
  localparam int W_M1_OUT   = 39;
  localparam int W_M2_OUT   = 52;
  localparam int W_MXY_OUT  = 53;

  typedef struct packed {
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic                  last_point;
  } in_t;

  typedef struct packed {
    logic [W_CNT_OUT-1:0]  point_count;
    logic [W_AREA_OUT-1:0] area_twice;
    logic [W_M1_OUT-1:0]   moment_x_six;
    logic [W_M1_OUT-1:0]   moment_y_six;
    logic [W_M2_OUT-1:0]   moment_xx_twelve;
    logic [W_MXY_OUT-1:0]  moment_xy_twentyfour;
    logic [W_M2_OUT-1:0]   moment_yy_twelve;
  } out_t;

  // status of the back end toward the top level
  typedef struct packed {
    logic pending;
    logic closing;
  } back_stat_t;

endpackage

>>> hdl/cpm_fifo.sv
module cpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             in_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             out_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  // handshake status
  assign in_ready  = (cnt_r != CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_push   = push & in_ready;
  assign do_pop    = pop & out_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hdl/cpm_front.sv
module cpm_front #(
  parameter int COORD_BITS = cpm_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = cpm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cpm_pkg::in_t          in_data,
  input  logic                  q_ready,
  output logic                  q_push,
  output logic [COORD_BITS-1:0] rec_px,
  output logic [COORD_BITS-1:0] rec_py,
  output logic [COORD_BITS-1:0] rec_cx,
  output logic [COORD_BITS-1:0] rec_cy,
  output logic [COORD_BITS-1:0] rec_fx,
  output logic [COORD_BITS-1:0] rec_fy,
  output logic                  rec_has_edge,
  output logic                  rec_last,
  output logic [COUNT_BITS-1:0] rec_count
);

  logic [COORD_BITS-1:0] first_x_r;
  logic [COORD_BITS-1:0] first_y_r;
  logic [COORD_BITS-1:0] prev_x_r;
  logic [COORD_BITS-1:0] prev_y_r;
  logic [COUNT_BITS-1:0] seen_r;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic                  start;
  logic                  accept;
  logic [COUNT_BITS-1:0] count_nxt;

  // low coordinate bits only
  assign x = COORD_BITS'(in_data.point_x);
  assign y = COORD_BITS'(in_data.point_y);

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;
  assign q_push   = accept;
  assign start    = (seen_r == '0);

  // saturating point count
  assign count_nxt = (seen_r == {COUNT_BITS{1'b1}}) ? seen_r : seen_r + 1'b1;

  // classify the point into a queue request
  always_comb begin
    rec_px       = prev_x_r;
    rec_py       = prev_y_r;
    rec_cx       = x;
    rec_cy       = y;
    rec_fx       = start ? x : first_x_r;
    rec_fy       = start ? y : first_y_r;
    rec_has_edge = !start;
    rec_last     = in_data.last_point;
    rec_count    = count_nxt;
  end

  // contour tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      seen_r    <= '0;
    end else if (accept) begin
      if (start) begin
        first_x_r <= x;
        first_y_r <= y;
      end
      prev_x_r <= x;
      prev_y_r <= y;
      seen_r   <= in_data.last_point ? '0 : count_nxt;
    end
  end

endmodule

>>> hdl/cpm_edge.sv
module cpm_edge #(
  parameter int COORD_BITS = cpm_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = cpm_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  logic [COUNT_BITS-1:0]        in_count,
  input  logic [COORD_BITS-1:0]        xc,
  input  logic [COORD_BITS-1:0]        yc,
  input  logic [COORD_BITS-1:0]        xf,
  input  logic [COORD_BITS-1:0]        yf,
  output logic                         out_valid,
  output logic                         out_last,
  output logic [COUNT_BITS-1:0]        out_count,
  output logic [cpm_pkg::W_AREA-1:0]   area_term,
  output logic [cpm_pkg::W_M1-1:0]     mx_term,
  output logic [cpm_pkg::W_M1-1:0]     my_term,
  output logic [cpm_pkg::W_MXX-1:0]    mxx_term,
  output logic [cpm_pkg::W_MXY-1:0]    mxy_term,
  output logic [cpm_pkg::W_MYY-1:0]    myy_term
);

  localparam int C     = COORD_BITS;
  localparam int SW    = C + 1;
  localparam int TW    = C + 2;
  localparam int PW    = 2 * C;
  localparam int DW    = 2 * C + 1;
  localparam int FXW   = 2 * C + 2;
  localparam int FXYW  = 2 * C + 3;
  localparam int MXW   = DW + SW + 1;
  localparam int MXXW  = DW + FXW + 1;
  localparam int MXYW  = DW + FXYW + 1;
  localparam int AWA   = cpm_pkg::W_AREA;
  localparam int AWM1  = cpm_pkg::W_M1;
  localparam int AWMXX = cpm_pkg::W_MXX;
  localparam int AWMXY = cpm_pkg::W_MXY;
  localparam int AWMYY = cpm_pkg::W_MYY;

  // tag pipeline
  logic [2:0]            vld_r;
  logic [2:0]            last_r;
  logic [COUNT_BITS-1:0] cnt1_r, cnt2_r, cnt3_r;

  // stage 1: coordinate products
  logic [SW-1:0]  sx_nxt, sy_nxt, sx1_r, sy1_r;
  logic [TW-1:0]  ty1, ty2;
  logic [PW-1:0]  pa_nxt, pb_nxt, pxx2_nxt, pyy2_nxt;
  logic [FXW-1:0] pxx1_nxt, pxy1_nxt, pxy2_nxt, pyy1_nxt;
  logic [PW-1:0]  pa_r, pb_r, pxx2_r, pyy2_r;
  logic [FXW-1:0] pxx1_r, pxy1_r, pxy2_r, pyy1_r;

  // stage 2: cross term and moment factors
  logic signed [DW-1:0] d_nxt, d_r;
  logic [FXW-1:0]       fxx_nxt, fyy_nxt, fxx_r, fyy_r;
  logic [FXYW-1:0]      fxy_nxt, fxy_r;
  logic [SW-1:0]        sx2_r, sy2_r;

  // stage 3: weighted terms
  logic signed [MXW-1:0]  mx_p, my_p;
  logic signed [MXXW-1:0] mxx_p, myy_p;
  logic signed [MXYW-1:0] mxy_p;

  always_comb begin
    sx_nxt   = SW'(xf) + SW'(xc);
    sy_nxt   = SW'(yf) + SW'(yc);
    ty1      = TW'({yc, 1'b0}) + TW'(yf);
    ty2      = TW'(yc) + TW'({yf, 1'b0});
    pa_nxt   = PW'(xf) * PW'(yc);
    pb_nxt   = PW'(xc) * PW'(yf);
    pxx1_nxt = FXW'(xc) * FXW'(sx_nxt);
    pxx2_nxt = PW'(xf) * PW'(xf);
    pxy1_nxt = FXW'(xc) * FXW'(ty1);
    pxy2_nxt = FXW'(xf) * FXW'(ty2);
    pyy1_nxt = FXW'(yc) * FXW'(sy_nxt);
    pyy2_nxt = PW'(yf) * PW'(yf);
  end

  always_comb begin
    d_nxt   = $signed({1'b0, pa_r}) - $signed({1'b0, pb_r});
    fxx_nxt = pxx1_r + FXW'(pxx2_r);
    fxy_nxt = FXYW'(pxy1_r) + FXYW'(pxy2_r);
    fyy_nxt = pyy1_r + FXW'(pyy2_r);
  end

  always_comb begin
    mx_p  = d_r * $signed({1'b0, sx2_r});
    my_p  = d_r * $signed({1'b0, sy2_r});
    mxx_p = d_r * $signed({1'b0, fxx_r});
    mxy_p = d_r * $signed({1'b0, fxy_r});
    myy_p = d_r * $signed({1'b0, fyy_r});
  end

  // tag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    last_r <= {last_r[1:0], in_last};
    cnt1_r <= in_count;
    cnt2_r <= cnt1_r;
    cnt3_r <= cnt2_r;
    sx1_r  <= sx_nxt;
    sy1_r  <= sy_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    pxx1_r <= pxx1_nxt;
    pxx2_r <= pxx2_nxt;
    pxy1_r <= pxy1_nxt;
    pxy2_r <= pxy2_nxt;
    pyy1_r <= pyy1_nxt;
    pyy2_r <= pyy2_nxt;
    d_r    <= d_nxt;
    fxx_r  <= fxx_nxt;
    fxy_r  <= fxy_nxt;
    fyy_r  <= fyy_nxt;
    sx2_r  <= sx1_r;
    sy2_r  <= sy1_r;
    area_term <= AWA'(d_r);
    mx_term   <= AWM1'(mx_p);
    my_term   <= AWM1'(my_p);
    mxx_term  <= AWMXX'(mxx_p);
    mxy_term  <= AWMXY'(mxy_p);
    myy_term  <= AWMYY'(myy_p);
  end

  assign out_valid = vld_r[2];
  assign out_last  = last_r[2];
  assign out_count = cnt3_r;

endmodule

>>> hdl/cpm_back.sv
module cpm_back #(
  parameter int COORD_BITS = cpm_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = cpm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [COORD_BITS-1:0] q_px,
  input  logic [COORD_BITS-1:0] q_py,
  input  logic [COORD_BITS-1:0] q_cx,
  input  logic [COORD_BITS-1:0] q_cy,
  input  logic [COORD_BITS-1:0] q_fx,
  input  logic [COORD_BITS-1:0] q_fy,
  input  logic                  q_has_edge,
  input  logic                  q_last,
  input  logic [COUNT_BITS-1:0] q_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cpm_pkg::out_t         out_data,
  output cpm_pkg::back_stat_t   stat
);

  localparam int WA    = cpm_pkg::W_AREA;
  localparam int WM1   = cpm_pkg::W_M1;
  localparam int WMXX  = cpm_pkg::W_MXX;
  localparam int WMXY  = cpm_pkg::W_MXY;
  localparam int WMYY  = cpm_pkg::W_MYY;
  localparam int OUTCW = cpm_pkg::W_CNT_OUT;

  typedef enum logic {
    PH_OPEN,
    PH_CLOSE
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  pending_r, pending_nxt;
  logic                  issue, issue_last, sel_close;
  logic                  s0_valid_r, s0_last_r;
  logic [COUNT_BITS-1:0] s0_count_r;
  logic [COORD_BITS-1:0] s0_xc_r, s0_yc_r, s0_xf_r, s0_yf_r;

  logic                  e_valid, e_last;
  logic [COUNT_BITS-1:0] e_count;
  logic [WA-1:0]         e_area;
  logic [WM1-1:0]        e_mx, e_my;
  logic [WMXX-1:0]       e_mxx;
  logic [WMXY-1:0]       e_mxy;
  logic [WMYY-1:0]       e_myy;

  logic [WA-1:0]   acc_area_r, sum_area_nxt, fin_area_r, cor_area;
  logic [WM1-1:0]  acc_mx_r, sum_mx_nxt, fin_mx_r, cor_mx;
  logic [WM1-1:0]  acc_my_r, sum_my_nxt, fin_my_r, cor_my;
  logic [WMXX-1:0] acc_mxx_r, sum_mxx_nxt, fin_mxx_r, cor_mxx;
  logic [WMXY-1:0] acc_mxy_r, sum_mxy_nxt, fin_mxy_r, cor_mxy;
  logic [WMYY-1:0] acc_myy_r, sum_myy_nxt, fin_myy_r, cor_myy;
  logic [COUNT_BITS-1:0] fin_count_r;
  logic                  fin_valid_r;
  logic                  neg;
  logic                  out_valid_r;
  cpm_pkg::out_t         out_data_r;

  // edge sequencer: open edge, then closing edge on a last point
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    q_pop       = 1'b0;
    issue       = 1'b0;
    issue_last  = 1'b0;
    sel_close   = 1'b0;
    if (out_valid_r && out_ready) begin
      pending_nxt = 1'b0;
    end
    if (q_valid) begin
      if (phase_r == PH_OPEN && q_has_edge) begin
        issue = 1'b1;
        if (q_last) begin
          phase_nxt = PH_CLOSE;
        end else begin
          q_pop = 1'b1;
        end
      end else if (q_last) begin
        if (!pending_r) begin
          issue       = 1'b1;
          issue_last  = 1'b1;
          sel_close   = 1'b1;
          q_pop       = 1'b1;
          phase_nxt   = PH_OPEN;
          pending_nxt = 1'b1;
        end
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  // sequencer state and issue register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPEN;
      pending_r  <= 1'b0;
      s0_valid_r <= 1'b0;
      s0_last_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pending_r  <= pending_nxt;
      s0_valid_r <= issue;
      s0_last_r  <= issue_last;
    end
  end

  // edge operands
  always_ff @(posedge clk) begin
    s0_count_r <= q_count;
    s0_xc_r    <= sel_close ? q_cx : q_px;
    s0_yc_r    <= sel_close ? q_cy : q_py;
    s0_xf_r    <= sel_close ? q_fx : q_cx;
    s0_yf_r    <= sel_close ? q_fy : q_cy;
  end

  cpm_edge #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_last   (s0_last_r),
    .in_count  (s0_count_r),
    .xc        (s0_xc_r),
    .yc        (s0_yc_r),
    .xf        (s0_xf_r),
    .yf        (s0_yf_r),
    .out_valid (e_valid),
    .out_last  (e_last),
    .out_count (e_count),
    .area_term (e_area),
    .mx_term   (e_mx),
    .my_term   (e_my),
    .mxx_term  (e_mxx),
    .mxy_term  (e_mxy),
    .myy_term  (e_myy)
  );

  // running sums, wrapping in their widths
  always_comb begin
    sum_area_nxt = acc_area_r + e_area;
    sum_mx_nxt   = acc_mx_r + e_mx;
    sum_my_nxt   = acc_my_r + e_my;
    sum_mxx_nxt  = acc_mxx_r + e_mxx;
    sum_mxy_nxt  = acc_mxy_r + e_mxy;
    sum_myy_nxt  = acc_myy_r + e_myy;
  end

  // accumulators, cleared after the closing edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_area_r  <= '0;
      acc_mx_r    <= '0;
      acc_my_r    <= '0;
      acc_mxx_r   <= '0;
      acc_mxy_r   <= '0;
      acc_myy_r   <= '0;
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= e_valid & e_last;
      if (e_valid) begin
        if (e_last) begin
          acc_area_r <= '0;
          acc_mx_r   <= '0;
          acc_my_r   <= '0;
          acc_mxx_r  <= '0;
          acc_mxy_r  <= '0;
          acc_myy_r  <= '0;
        end else begin
          acc_area_r <= sum_area_nxt;
          acc_mx_r   <= sum_mx_nxt;
          acc_my_r   <= sum_my_nxt;
          acc_mxx_r  <= sum_mxx_nxt;
          acc_mxy_r  <= sum_mxy_nxt;
          acc_myy_r  <= sum_myy_nxt;
        end
      end
    end
  end

  // final sums of one contour
  always_ff @(posedge clk) begin
    if (e_valid && e_last) begin
      fin_area_r  <= sum_area_nxt;
      fin_mx_r    <= sum_mx_nxt;
      fin_my_r    <= sum_my_nxt;
      fin_mxx_r   <= sum_mxx_nxt;
      fin_mxy_r   <= sum_mxy_nxt;
      fin_myy_r   <= sum_myy_nxt;
      fin_count_r <= e_count;
    end
  end

  // sign correction by the area sign
  always_comb begin
    neg     = fin_area_r[WA-1];
    cor_area = neg ? (WA'(0) - fin_area_r) : fin_area_r;
    cor_mx   = neg ? (WM1'(0) - fin_mx_r) : fin_mx_r;
    cor_my   = neg ? (WM1'(0) - fin_my_r) : fin_my_r;
    cor_mxx  = neg ? (WMXX'(0) - fin_mxx_r) : fin_mxx_r;
    cor_mxy  = neg ? (WMXY'(0) - fin_mxy_r) : fin_mxy_r;
    cor_myy  = neg ? (WMYY'(0) - fin_myy_r) : fin_myy_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid_r) begin
      out_data_r.point_count          <= OUTCW'(fin_count_r);
      out_data_r.area_twice           <= cor_area[cpm_pkg::W_AREA_OUT-1:0];
      out_data_r.moment_x_six         <= cor_mx[cpm_pkg::W_M1_OUT-1:0];
      out_data_r.moment_y_six         <= cor_my[cpm_pkg::W_M1_OUT-1:0];
      out_data_r.moment_xx_twelve     <= cor_mxx[cpm_pkg::W_M2_OUT-1:0];
      out_data_r.moment_xy_twentyfour <= cor_mxy[cpm_pkg::W_MXY_OUT-1:0];
      out_data_r.moment_yy_twelve     <= cor_myy[cpm_pkg::W_M2_OUT-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign stat.pending = pending_r;
  assign stat.closing = (phase_r == PH_CLOSE);

endmodule

>>> hdl/contour_polygon_moments.sv
// Polygon area and first and second moments of one closed contour by Green's
// theorem, one point per request, the last point marked. The front end tracks
// the first and previous points and the point count and pushes each point into
// a QUEUE_DEPTH entry queue; the back end turns it into edges, runs each edge
// through a three stage multiply pipeline and adds the terms into exact
// wrapping accumulators. Within a contour the back end takes one point per
// cycle while the queue holds points; a last point holds the queue head for
// its own edge and then the closing edge of the edge pipeline. The result is
// negated as a whole when the area is negative. Only one result is in flight:
// the closing edge of the next contour waits until the previous result is
// taken, so short contours or a slow receiver fill the queue and then stall
// the input.
// The divisions by 2, 6, 12 and 24 are left to the consumer.
`include "contour_polygon_moments_assert.svh"

module contour_polygon_moments #(
  parameter int COORD_BITS  = cpm_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS  = cpm_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = cpm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cpm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cpm_pkg::out_t out_data
);

  localparam int REC_W = 6 * COORD_BITS + COUNT_BITS + 2;

  logic                  push, fifo_in_ready;
  logic [COORD_BITS-1:0] rec_px, rec_py, rec_cx, rec_cy, rec_fx, rec_fy;
  logic                  rec_has_edge, rec_last;
  logic [COUNT_BITS-1:0] rec_count;
  logic [REC_W-1:0]      fifo_wdata, fifo_rdata;
  logic                  q_valid, q_pop;
  logic [COORD_BITS-1:0] q_px, q_py, q_cx, q_cy, q_fx, q_fy;
  logic                  q_has_edge, q_last;
  logic [COUNT_BITS-1:0] q_count;
  cpm_pkg::back_stat_t   back_stat;

  // point tracking
  cpm_front #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .q_ready      (fifo_in_ready),
    .q_push       (push),
    .rec_px       (rec_px),
    .rec_py       (rec_py),
    .rec_cx       (rec_cx),
    .rec_cy       (rec_cy),
    .rec_fx       (rec_fx),
    .rec_fy       (rec_fy),
    .rec_has_edge (rec_has_edge),
    .rec_last     (rec_last),
    .rec_count    (rec_count)
  );

  // queue between front and back
  assign fifo_wdata = {rec_last, rec_has_edge, rec_count,
                       rec_fx, rec_fy, rec_px, rec_py, rec_cx, rec_cy};

  cpm_fifo #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (fifo_wdata),
    .in_ready  (fifo_in_ready),
    .pop       (q_pop),
    .rdata     (fifo_rdata),
    .out_valid (q_valid)
  );

  assign {q_last, q_has_edge, q_count, q_fx, q_fy, q_px, q_py, q_cx, q_cy} = fifo_rdata;

  // edge arithmetic and accumulation
  cpm_back #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_px       (q_px),
    .q_py       (q_py),
    .q_cx       (q_cx),
    .q_cy       (q_cy),
    .q_fx       (q_fx),
    .q_fy       (q_fy),
    .q_has_edge (q_has_edge),
    .q_last     (q_last),
    .q_count    (q_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .stat       (back_stat)
  );

  // a shown result is always the one booked by the sequencer
  `CPM_ASSERT_IMP(a_out_pending, out_valid, back_stat.pending)
  // no second result right behind a taken one
  `CPM_ASSERT_NXT(a_one_result, out_valid && out_ready, !out_valid)
  // the closing edge phase holds the queue head
  `CPM_ASSERT_IMP(a_close_head, back_stat.closing, q_valid)
  // the back end pops only a present entry
  `CPM_ASSERT_IMP(a_pop_head, q_pop, q_valid)

endmodule

>>> sim/contour_polygon_moments_test.sv
`timescale 1ns / 100ps

module contour_polygon_moments_test;
  import cpm_pkg::*;

  localparam int RANDOM_POINTS = 1280;
  localparam int WIND_LAPS     = 8;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_PRINTED   = 50;

  // style of the coordinates within one random contour
  typedef enum int {
    COORD_FULL,
    COORD_EXTREME,
    COORD_BOX
  } coord_style_t;

  // predicts the moment sums of each contour and checks the results
  class moment_scoreboard;
    logic [IN_COORD_W-1:0]     first_x, first_y, prev_x, prev_y;
    logic [COUNT_BITS_DEF-1:0] count;
    logic [W_AREA-1:0]         area_acc;
    logic [W_M1-1:0]           mx_acc, my_acc;
    logic [W_MXX-1:0]          mxx_acc;
    logic [W_MXY-1:0]          mxy_acc;
    logic [W_MYY-1:0]          myy_acc;
    out_t                      expected_results[$];
    int mismatches;
    int results_checked;
    int points_noted;
    int negated_contours;
    int saturated_contours;

    function new();
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      mismatches = 0;
      results_checked = 0;
      points_noted = 0;
      negated_contours = 0;
      saturated_contours = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      count = '0;
      area_acc = '0;
      mx_acc = '0;
      my_acc = '0;
      mxx_acc = '0;
      mxy_acc = '0;
      myy_acc = '0;
    endfunction

    // green's theorem terms of one edge, wrapping in each sum's width
    function void add_edge_terms(logic [63:0] xc, logic [63:0] yc,
                                 logic [63:0] xf, logic [63:0] yf);
      logic [63:0] d, sx, sy, t;
      d = xf * yc - xc * yf;
      sx = xf + xc;
      sy = yf + yc;
      area_acc = area_acc + d[W_AREA-1:0];
      t = d * sx;
      mx_acc = mx_acc + t[W_M1-1:0];
      t = d * sy;
      my_acc = my_acc + t[W_M1-1:0];
      t = d * (xc * sx + xf * xf);
      mxx_acc = mxx_acc + t[W_MXX-1:0];
      t = d * (xc * (sy + yc) + xf * (sy + yf));
      mxy_acc = mxy_acc + t[W_MXY-1:0];
      t = d * (yc * sy + yf * yf);
      myy_acc = myy_acc + t[W_MYY-1:0];
    endfunction

    function void note_point(in_t p);
      out_t r;
      points_noted++;
      if (count == '0) begin
        first_x = p.point_x;
        first_y = p.point_y;
      end else begin
        add_edge_terms(prev_x, prev_y, p.point_x, p.point_y);
      end
      prev_x = p.point_x;
      prev_y = p.point_y;
      if (count != '1) begin
        count = count + 1'b1;
      end
      if (!p.last_point) return;

      // closing edge back to the first point
      add_edge_terms(p.point_x, p.point_y, first_x, first_y);

      // negative wrapped area flips every sum
      if (area_acc[W_AREA-1]) begin
        area_acc = -area_acc;
        mx_acc = -mx_acc;
        my_acc = -my_acc;
        mxx_acc = -mxx_acc;
        mxy_acc = -mxy_acc;
        myy_acc = -myy_acc;
        negated_contours++;
      end
      if (count == '1) saturated_contours++;
      r.point_count          = count[W_CNT_OUT-1:0];
      r.area_twice           = area_acc[W_AREA_OUT-1:0];
      r.moment_x_six         = mx_acc[W_M1_OUT-1:0];
      r.moment_y_six         = my_acc[W_M1_OUT-1:0];
      r.moment_xx_twelve     = mxx_acc[W_M2_OUT-1:0];
      r.moment_xy_twentyfour = mxy_acc[W_MXY_OUT-1:0];
      r.moment_yy_twelve     = myy_acc[W_M2_OUT-1:0];
      expected_results.insert(expected_results.size(), r);
      clear_sums();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("mismatch in result %0d: %s got %0h expected %0h",
                 results_checked, what, got, want);
      end
    endtask

    task compare_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(out_t r);
      out_t e;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, area", r.area_twice, '0);
        return;
      end
      e = expected_results.pop_front();
      compare_field("point_count", r.point_count, e.point_count);
      compare_field("area_twice", r.area_twice, e.area_twice);
      compare_field("moment_x_six", r.moment_x_six, e.moment_x_six);
      compare_field("moment_y_six", r.moment_y_six, e.moment_y_six);
      compare_field("moment_xx_twelve", r.moment_xx_twelve, e.moment_xx_twelve);
      compare_field("moment_xy_twentyfour", r.moment_xy_twentyfour,
                    e.moment_xy_twentyfour);
      compare_field("moment_yy_twelve", r.moment_yy_twelve, e.moment_yy_twelve);
      results_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  moment_scoreboard sb = new();
  int cycle_count = 0;
  int input_stall_cycles = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  contour_polygon_moments DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_point(in_data);
      end else if (in_valid) begin
        input_stall_cycles++;
      end
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // one point request, then a gap when the burst runs out
  task automatic offer_point(input logic [IN_COORD_W-1:0] x,
                             input logic [IN_COORD_W-1:0] y, input logic last);
    in_t p;
    int gap;
    p.point_x = x;
    p.point_y = y;
    p.last_point = last;
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end
  endtask

  function automatic logic [IN_COORD_W-1:0] pick_coord(coord_style_t style,
                                                       logic [IN_COORD_W-1:0] base);
    case (style)
      COORD_FULL:    return IN_COORD_W'($urandom_range(0, 4095));
      COORD_EXTREME: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      default:       return base + IN_COORD_W'($urandom_range(0, 15));
    endcase
  endfunction

  // receiver: ready patterns of its own, with one long hold-off
  initial begin : receiver
    int mode, run, k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results_checked >= 30) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(10, 150);
      k = $urandom_range(2, 6);
      for (int i = 0; i < run; i++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((i / k) % 2 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int random_points, len, sel;
    coord_style_t style;
    logic [IN_COORD_W-1:0] base;
    random_points = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point contours at both corners
    offer_point(12'hFFF, 12'hFFF, 1'b1);
    offer_point(12'h000, 12'h000, 1'b1);
    // full frame square, clockwise then counterclockwise
    offer_point(12'h000, 12'h000, 1'b0);
    offer_point(12'hFFF, 12'h000, 1'b0);
    offer_point(12'hFFF, 12'hFFF, 1'b0);
    offer_point(12'h000, 12'hFFF, 1'b1);
    offer_point(12'h000, 12'hFFF, 1'b0);
    offer_point(12'hFFF, 12'hFFF, 1'b0);
    offer_point(12'hFFF, 12'h000, 1'b0);
    offer_point(12'h000, 12'h000, 1'b1);
    // zero area: a diagonal segment and three collinear points
    offer_point(12'h000, 12'h000, 1'b0);
    offer_point(12'hFFF, 12'hFFF, 1'b1);
    offer_point(12'h010, 12'h020, 1'b0);
    offer_point(12'h020, 12'h040, 1'b0);
    offer_point(12'h7FF, 12'hFFE, 1'b1);
    // large triangle with alternating bit patterns
    offer_point(12'hFFF, 12'h000, 1'b0);
    offer_point(12'h000, 12'hFFF, 1'b0);
    offer_point(12'hAAA, 12'h555, 1'b1);

    // random contours, mostly short
    while (random_points < RANDOM_POINTS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) len = $urandom_range(1, 8);
      else if (sel < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      style = coord_style_t'($urandom_range(0, 2));
      base = IN_COORD_W'($urandom_range(0, 4080));
      for (int i = 0; i < len; i++) begin
        offer_point(pick_coord(style, base), pick_coord(style, base), i == len - 1);
      end
      random_points += len;
    end

    // full frame square wound several times so the sums wrap
    for (int lap = 0; lap < WIND_LAPS; lap++) begin
      offer_point(12'h000, 12'h000, 1'b0);
      offer_point(12'hFFF, 12'h000, 1'b0);
      offer_point(12'hFFF, 12'hFFF, 1'b0);
      offer_point(12'h000, 12'hFFF, lap == WIND_LAPS - 1);
    end
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points in %0d contours checked, %0d with negated sums, %0d saturated",
             sb.points_noted, sb.results_checked, sb.negated_contours,
             sb.saturated_contours);
    $display("input stalled %0d cycles, long output hold-off %0s",
             input_stall_cycles, long_hold_done ? "done" : "not reached");
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
